>>> rtl/core/ree_pkg.sv
package ree_pkg;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_MOD  = 3'd5
  } opr_e;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_PCT   = 8'h25;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  localparam logic [0:0] CFG_INPUT_RADIX  = 1'b0;
  localparam logic [0:0] CFG_OUTPUT_RADIX = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [6:0] digit_char;
    logic       negative;
    logic       error;
    logic       last;
  } out_item_t;

  // Classified command from front to back.
  typedef struct packed {
    logic       finish;
    logic       is_opr;
    opr_e       opr;
    logic [7:0] char_code;
  } cmd_t;

  function automatic logic [6:0] digit_ascii(input logic [3:0] d);
    logic [6:0] r;
    if (d < 4'd10) r = 7'(CHAR_ZERO) + 7'(d);
    else r = 7'(CHAR_UA) + 7'(d) - 7'd10;
    return r;
  endfunction

endpackage

>>> rtl/core/ree_front.sv
module ree_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ree_pkg::in_item_t in_data_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output ree_pkg::cmd_t     q_cmd_o
);

  localparam int Depth = 2;

  ree_pkg::cmd_t mem_q [Depth];
  logic [0:0] wptr_q, rptr_q;
  logic [1:0] cnt_q;
  ree_pkg::cmd_t cmd;
  logic push, pop;

  always_comb begin
    cmd.finish    = in_data_i.op;
    cmd.char_code = in_data_i.char_code;
    cmd.is_opr    = 1'b1;
    case (in_data_i.char_code)
      ree_pkg::CHAR_PLUS:  cmd.opr = ree_pkg::OP_ADD;
      ree_pkg::CHAR_MINUS: cmd.opr = ree_pkg::OP_SUB;
      ree_pkg::CHAR_STAR:  cmd.opr = ree_pkg::OP_MUL;
      ree_pkg::CHAR_SLASH: cmd.opr = ree_pkg::OP_DIV;
      ree_pkg::CHAR_PCT:   cmd.opr = ree_pkg::OP_MOD;
      default: begin
        cmd.opr    = ree_pkg::OP_NONE;
        cmd.is_opr = 1'b0;
      end
    endcase
  end

  assign in_stall_o = (cnt_q == 2'(Depth));
  assign push = in_valid_i && !in_stall_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop = q_valid_o && q_ready_i;
  assign q_cmd_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + 1'b1;
      if (pop) rptr_q <= rptr_q + 1'b1;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> rtl/core/ree_back.sv
module ree_back #(
  parameter int DataWidth = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [4:0]         input_radix_i,
  input  logic [1:0]         output_radix_code_i,
  input  logic               q_valid_i,
  output logic               q_ready_o,
  input  ree_pkg::cmd_t      q_cmd_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ree_pkg::out_item_t out_data_o
);

  localparam int CntW = $clog2(DataWidth + 1);
  localparam int IdxW = $clog2(DataWidth);
  localparam int NibW = (DataWidth + 3) / 4;
  localparam int PadW = 4 * NibW;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIV    = 3'd1;
  localparam logic [2:0] S_FIN    = 3'd2;
  localparam logic [2:0] S_CONV   = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;
  localparam logic [2:0] S_DIGMUL = 3'd5;

  logic [2:0] st_q, st_d;
  logic [DataWidth-1:0] acc_q, opd_q, mag_q, quo_q, rem_q, dvs_q;
  logic [DataWidth-1:0] prod_q;
  logic [PadW-1:0] dec_q;
  logic [7:0] dchar_q;
  ree_pkg::opr_e pend_q;
  ree_pkg::opr_e newop_q;
  logic err_q, fin_q, neg_q;
  logic [CntW-1:0] bit_q, cnt_q, emit_q;
  logic [3:0] store_q [DataWidth];
  logic [3:0] rd_q;
  logic rd_ok_q;
  logic ovalid_q;
  ree_pkg::out_item_t odata_q;

  logic [DataWidth-1:0] a_mag, b_mag, rem_sh, sum_w, bvec, res_w, res_mag;
  logic rem_ge;
  logic [DataWidth:0] rem_tr;
  logic [IdxW-1:0] shamt;
  logic [3:0] dig_mask;
  logic [DataWidth-1:0] digit_w;
  logic conv_done;
  logic [7:0] dec_t;
  logic [14:0] dec_m;
  logic [3:0] dec_qd;
  logic [7:0] dec_r;
  logic set_err, set_dig;

  assign a_mag = acc_q[DataWidth-1] ? -acc_q : acc_q;
  assign b_mag = opd_q[DataWidth-1] ? -opd_q : opd_q;
  assign rem_sh = {rem_q[DataWidth-2:0], mag_q[DataWidth-1]};
  assign rem_tr = {rem_q, mag_q[DataWidth-1]} - {1'b0, dvs_q};
  assign rem_ge = !rem_tr[DataWidth];

  // Decimal step: remainder and next four dividend bits, quotient by reciprocal.
  assign dec_t  = {rem_q[3:0], dec_q[PadW-1 -: 4]};
  assign dec_m  = 15'(dec_t) * 15'd205;
  assign dec_qd = dec_m[14:11];
  assign dec_r  = dec_t - 8'(dec_qd) * 8'd10;

  always_comb begin
    case (output_radix_code_i)
      2'd0: begin shamt = IdxW'(1); dig_mask = 4'h1; end
      2'd1: begin shamt = IdxW'(3); dig_mask = 4'h7; end
      default: begin shamt = IdxW'(4); dig_mask = 4'hF; end
    endcase
  end

  // Digit of the current character: letters A-F map to 10-15, others code-48.
  always_comb begin
    if (dchar_q >= ree_pkg::CHAR_UA && dchar_q <= ree_pkg::CHAR_UF)
      digit_w = DataWidth'(dchar_q - ree_pkg::CHAR_UA) + DataWidth'(10);
    else
      digit_w = DataWidth'(dchar_q) - DataWidth'(ree_pkg::CHAR_ZERO);
  end

  assign sum_w = acc_q + opd_q;
  assign bvec = acc_q - opd_q;

  always_comb begin
    res_w = opd_q;
    case (pend_q)
      ree_pkg::OP_ADD: res_w = sum_w;
      ree_pkg::OP_SUB: res_w = bvec;
      ree_pkg::OP_MUL: res_w = prod_q;
      ree_pkg::OP_DIV:
        res_w = (acc_q[DataWidth-1] != opd_q[DataWidth-1]) ? -quo_q : quo_q;
      ree_pkg::OP_MOD: res_w = acc_q[DataWidth-1] ? -rem_q : rem_q;
      default: res_w = opd_q;
    endcase
  end

  assign res_mag = res_w[DataWidth-1] ? -res_w : res_w;

  // At least one digit is produced, so zero prints as a single zero.
  assign conv_done = ((mag_q == '0) && (cnt_q != '0)) || (cnt_q == CntW'(DataWidth));
  assign q_ready_o = (st_q == S_IDLE);

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (q_valid_i) begin
        if (!q_cmd_i.finish && !q_cmd_i.is_opr) st_d = S_DIGMUL;
        else if (q_valid_i) st_d = S_DIV;
      end
      S_DIGMUL: st_d = S_IDLE;
      S_DIV: if (bit_q == '0) st_d = S_FIN;
      S_FIN: st_d = fin_q ? S_CONV : S_IDLE;
      S_CONV: if (conv_done && (err_q || !ovalid_q || !out_stall_i))
        st_d = S_EMIT;
      S_EMIT: if (!ovalid_q || !out_stall_i)
        st_d = (emit_q == '0 && !rd_ok_q) ? S_IDLE : S_EMIT;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && q_valid_i) begin
      dchar_q <= q_cmd_i.char_code;
      newop_q <= q_cmd_i.opr;
      fin_q   <= q_cmd_i.finish;
      prod_q  <= '0;
      mag_q   <= a_mag;
      dvs_q   <= b_mag;
      rem_q   <= '0;
      quo_q   <= '0;
      bit_q   <= CntW'(DataWidth);
    end else if (st_q == S_DIV && bit_q != '0) begin
      if (rem_ge) rem_q <= rem_tr[DataWidth-1:0];
      else rem_q <= rem_sh;
      quo_q <= {quo_q[DataWidth-2:0], rem_ge};
      mag_q <= {mag_q[DataWidth-2:0], 1'b0};
      // Shift-add product, multiplier bits taken most significant first.
      prod_q <= {prod_q[DataWidth-2:0], 1'b0} +
                (opd_q[IdxW'(bit_q - 1'b1)] ? acc_q : '0);
      bit_q <= bit_q - 1'b1;
    end else if (st_q == S_FIN) begin
      mag_q <= res_mag;
      dec_q <= PadW'(res_mag);
      neg_q <= res_w[DataWidth-1];
      rem_q <= '0;
      quo_q <= '0;
    end else if (st_q == S_CONV && !conv_done) begin
      // Radix 10: four dividend bits per cycle; powers of two by shift.
      if (output_radix_code_i == 2'd2) begin
        if (bit_q == '0) begin
          store_q[cnt_q[IdxW-1:0]] <= 4'(rem_q);
          cnt_q <= cnt_q + 1'b1;
          mag_q <= quo_q;
          dec_q <= PadW'(quo_q);
          rem_q <= '0;
          quo_q <= '0;
          bit_q <= CntW'(NibW);
        end else begin
          rem_q <= DataWidth'(dec_r);
          quo_q <= {quo_q[DataWidth-5:0], dec_qd};
          dec_q <= {dec_q[PadW-5:0], 4'b0000};
          bit_q <= bit_q - 1'b1;
        end
      end else begin
        store_q[cnt_q[IdxW-1:0]] <= 4'(mag_q) & dig_mask;
        cnt_q <= cnt_q + 1'b1;
        mag_q <= mag_q >> shamt;
      end
    end
    if (st_q == S_DIV && bit_q == '0) begin
      bit_q  <= CntW'(NibW);
      cnt_q  <= '0;
    end
    if (st_q == S_CONV && conv_done) begin
      emit_q <= cnt_q;
      rd_ok_q <= 1'b0;
    end
    if (st_q == S_EMIT && (!ovalid_q || !out_stall_i) && emit_q != '0) begin
      rd_q <= store_q[IdxW'(emit_q - 1'b1)];
      rd_ok_q <= 1'b1;
      emit_q <= emit_q - 1'b1;
    end else if (st_q == S_EMIT && (!ovalid_q || !out_stall_i)) begin
      rd_ok_q <= 1'b0;
    end
  end

  assign set_err = (st_q == S_CONV) && conv_done && err_q;
  assign set_dig = (st_q == S_EMIT) && (!ovalid_q || !out_stall_i) && rd_ok_q && !err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      acc_q    <= '0;
      opd_q    <= '0;
      pend_q   <= ree_pkg::OP_NONE;
      err_q    <= 1'b0;
      ovalid_q <= 1'b0;
      odata_q  <= '0;
    end else begin
      st_q <= st_d;
      if (set_err || set_dig) ovalid_q <= 1'b1;
      else if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
      if (st_q == S_DIGMUL)
        opd_q <= DataWidth'(opd_q * DataWidth'(input_radix_i)) + digit_w;
      if (st_q == S_FIN) begin
        if ((pend_q == ree_pkg::OP_DIV || pend_q == ree_pkg::OP_MOD) &&
            opd_q == '0) begin
          err_q <= 1'b1;
        end else begin
          acc_q <= res_w;
        end
        opd_q  <= '0;
        pend_q <= fin_q ? ree_pkg::OP_NONE : newop_q;
      end
      if (set_err) begin
        odata_q  <= '{digit_char: 7'(ree_pkg::CHAR_ZERO), negative: 1'b0,
                      error: 1'b1, last: 1'b1};
      end
      if (set_dig) begin
        odata_q  <= '{digit_char: ree_pkg::digit_ascii(rd_q), negative: neg_q,
                      error: 1'b0, last: (emit_q == '0)};
      end
      if (st_q == S_EMIT && st_d == S_IDLE) begin
        acc_q <= '0;
        opd_q <= '0;
        err_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

endmodule

>>> rtl/core/radix_expression_evaluator.sv
// Left-to-right calculator taking one expression character per transaction.
// The front stage classifies each character (operator or digit) into a
// two-entry queue; the back stage runs it. A digit is folded into the
// operand in the back stage. An operator or finish runs a shared
// one-bit-per-cycle restoring divider and shift-add multiplier. Finish then
// converts the magnitude: radix 2/8/16 by shift, radix 10 four dividend
// bits a cycle; digits then stream out one per cycle unless stalled, most
// significant first, with last on the final one. A zero result prints as
// one zero digit. A divide by zero yields a single error transaction at
// finish. Configure only while idle.
module radix_expression_evaluator #(
  parameter int DataWidth = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ree_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ree_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [0:0]         cfg_index_i,
  input  logic [4:0]         cfg_data_i
);

  logic [4:0] in_radix_q;
  logic [1:0] out_code_q;
  logic q_valid, q_ready;
  ree_pkg::cmd_t q_cmd;

  assign cfg_ready_o = 1'b1;

  // Hold configuration; write it only while idle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_radix_q <= 5'd10;
      out_code_q <= 2'd2;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ree_pkg::CFG_INPUT_RADIX:  in_radix_q <= cfg_data_i;
        ree_pkg::CFG_OUTPUT_RADIX: out_code_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  ree_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cmd_o(q_cmd)
  );

  ree_back #(.DataWidth(DataWidth)) u_back (
    .clk_i, .rst_ni,
    .input_radix_i(in_radix_q), .output_radix_code_i(out_code_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_cmd_i(q_cmd),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule
